/* design/hism_pkg.sv */
// Package for the half insertion sort merge block.
// Sizes, key and count types, and the control word broadcast along the cell chain.
// No dependencies.
package hism_pkg;

   localparam int MAX_KEYS   = 256;
   localparam int KEY_BITS   = 32;
   localparam int COUNT_BITS = $clog2(MAX_KEYS + 1);

   typedef logic signed [KEY_BITS-1:0] key_type;
   typedef logic [COUNT_BITS-1:0]      count_type;

   typedef struct packed {
      logic insert;   // place the broadcast key in order
      logic shift;    // move every key one cell towards the head
   } cell_ctl_type;

endpackage

/* design/hism_cell.sv */
// One cell of the sorting chain: holds one key and compares it with the broadcast key.
// Depends on hism_pkg.
module hism_cell (
   input  logic                  clock,
   input  hism_pkg::cell_ctl_type ctl,
   input  hism_pkg::key_type     in_key,
   input  logic                  occupied,
   input  hism_pkg::key_type     prev_key,
   input  logic                  prev_lt,
   input  hism_pkg::key_type     next_key,
   output hism_pkg::key_type     key,
   output logic                  lt
);

   hism_pkg::key_type key_ff;
   hism_pkg::key_type key_in;

   // new key belongs at or before this cell
   assign lt  = !occupied || (in_key < key_ff);
   assign key = key_ff;

   always_comb begin
      key_in = key_ff;
      priority if (ctl.shift) begin
         key_in = next_key;
      end else if (ctl.insert && lt) begin
         key_in = prev_lt ? prev_key : in_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

/* design/hism_chain.sv */
// Row of MAX_KEYS sorting cells kept in ascending order, head at cell zero.
// Depends on hism_pkg and hism_cell.
module hism_chain (
   input  logic                   clock,
   input  hism_pkg::cell_ctl_type ctl,
   input  hism_pkg::key_type      in_key,
   input  hism_pkg::count_type    fill,
   output hism_pkg::key_type      head_key
);

   hism_pkg::key_type cell_key [hism_pkg::MAX_KEYS];
   logic              cell_lt  [hism_pkg::MAX_KEYS];

   for (genvar i = 0; i < hism_pkg::MAX_KEYS; i++) begin : g_cell
      hism_pkg::key_type prev_key;
      hism_pkg::key_type next_key;
      logic              prev_lt;
      logic              occupied;

      assign occupied = hism_pkg::COUNT_BITS'(i) < fill;

      if (i == 0) begin : g_head
         assign prev_key = '0;
         assign prev_lt  = 1'b0;
      end else begin : g_body
         assign prev_key = cell_key[i-1];
         assign prev_lt  = cell_lt[i-1];
      end

      if (i == hism_pkg::MAX_KEYS - 1) begin : g_tail
         assign next_key = '0;
      end else begin : g_inner
         assign next_key = cell_key[i+1];
      end

      hism_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .in_key   (in_key),
         .occupied (occupied),
         .prev_key (prev_key),
         .prev_lt  (prev_lt),
         .next_key (next_key),
         .key      (cell_key[i]),
         .lt       (cell_lt[i])
      );
   end

   assign head_key = cell_key[0];

endmodule

/* design/half_insertion_sort_merge.sv */
// Insertion sorter: keys are kept in order on load, sorted words leave in ascending order.
// Load: one word per cycle unless stalled; inserted into the chain if room, at the accepting edge.
// Fetch: word valid the cycle after acceptance; one per cycle unless rsp_stall holds the output.
// A final key leaves the set sorted at once, with no sorting pass between load and fetch.
// Reset (synchronous) clears count, read pointer, ready flag and output valid; cells keep no reset.
// Depends on hism_pkg and hism_chain.
module half_insertion_sort_merge (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_key_value,
   input  logic        req_final_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_sorted_key,
   output logic        rsp_last_of_set,
   output logic        rsp_empty_read
);

   hism_pkg::count_type    count_ff, count_in;
   hism_pkg::count_type    rp_ff, rp_in;
   hism_pkg::count_type    fill;
   logic                   ready_ff, ready_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_key_ff, rsp_key_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_empty_ff, rsp_empty_in;
   logic                   accept, do_load, do_fetch, empty, room, last;
   hism_pkg::cell_ctl_type ctl;
   hism_pkg::key_type      in_key, head_key;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign do_load   = accept && !req_action;
   assign do_fetch  = accept && req_action;

   // load after a sorted set starts a new one
   assign fill  = ready_ff ? '0 : count_ff;
   assign room  = fill < hism_pkg::COUNT_BITS'(hism_pkg::MAX_KEYS);
   assign empty = !ready_ff || (rp_ff >= count_ff);
   assign last  = hism_pkg::COUNT_BITS'(rp_ff + hism_pkg::COUNT_BITS'(1)) == count_ff;

   assign in_key     = hism_pkg::KEY_BITS'(req_key_value);
   assign ctl.insert = do_load && room;
   assign ctl.shift  = do_fetch && !empty;

   hism_chain u_chain (
      .clock    (clock),
      .ctl      (ctl),
      .in_key   (in_key),
      .fill     (fill),
      .head_key (head_key)
   );

   always_comb begin
      count_in     = count_ff;
      rp_in        = rp_ff;
      ready_in     = ready_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_key_in   = rsp_key_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      if (do_load) begin
         count_in = hism_pkg::COUNT_BITS'(fill + hism_pkg::COUNT_BITS'(room));
         rp_in    = '0;
         ready_in = req_final_key;
      end
      if (do_fetch) begin
         rsp_valid_in = 1'b1;
         rsp_empty_in = empty;
         rsp_last_in  = !empty && last;
         rsp_key_in   = empty ? '0 : 32'(unsigned'(head_key));
         if (!empty) begin
            rp_in = hism_pkg::COUNT_BITS'(rp_ff + hism_pkg::COUNT_BITS'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rp_ff        <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rp_ff        <= rp_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_key_ff   <= rsp_key_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sorted_key  = rsp_key_ff;
   assign rsp_last_of_set = rsp_last_ff;
   assign rsp_empty_read  = rsp_empty_ff;

endmodule

/* test/half_insertion_sort_merge_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for half_insertion_sort_merge: loads key sets, fetches sorted words
// and compares each against an in-bench two-run insertion sort with stable merge.
// Depends on hism_pkg and the half_insertion_sort_merge RTL.
module half_insertion_sort_merge_tb;

   localparam bit ACT_LOAD  = 1'b0;
   localparam bit ACT_FETCH = 1'b1;
   localparam int CYCLE_LIMIT = 400000;
   localparam hism_pkg::key_type KEY_MAX = 32'sh7fffffff;
   localparam hism_pkg::key_type KEY_MIN = 32'sh80000000;

   typedef struct {
      hism_pkg::key_type key;
      logic              last;
      logic              empty;
   } sorted_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = 1'b0;
   logic [31:0] req_key_value = '0;
   logic        req_final_key = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_sorted_key;
   logic        rsp_last_of_set;
   logic        rsp_empty_read;

   // predictor state
   hism_pkg::key_type set_keys [hism_pkg::MAX_KEYS];
   hism_pkg::key_type merge_keys [hism_pkg::MAX_KEYS];
   int unsigned       set_count = 0;
   int unsigned       fetch_index = 0;
   bit                set_sorted = 1'b0;

   sorted_word_type expected_sorted [$];
   int  failures = 0;
   int  sent_words = 0;
   int  cycle_count = 0;
   bit  idle_on = 1'b1;
   int  hold_request = 0;
   int  hold_left = 0;
   int  stall_burst = 0;

   half_insertion_sort_merge uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_key_value  (req_key_value),
      .req_final_key  (req_final_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sorted_key (rsp_sorted_key),
      .rsp_last_of_set(rsp_last_of_set),
      .rsp_empty_read (rsp_empty_read)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic void insertion_run(int unsigned lo, int unsigned hi);
      hism_pkg::key_type k;
      int unsigned       j;
      for (int unsigned i = lo + 1; i < hi; i++) begin
         k = set_keys[i];
         j = i;
         while (j > lo && set_keys[j-1] > k) begin
            set_keys[j] = set_keys[j-1];
            j--;
         end
         set_keys[j] = k;
      end
   endfunction

   function automatic void sort_halves_and_merge();
      int unsigned mid;
      int unsigned a;
      int unsigned b;
      int unsigned o;
      mid = set_count / 2;
      a = 0;
      b = mid;
      o = 0;
      insertion_run(0, mid);
      insertion_run(mid, set_count);
      while (a < mid && b < set_count) begin
         if (!(set_keys[a] > set_keys[b])) begin
            merge_keys[o] = set_keys[a];
            a++;
         end else begin
            merge_keys[o] = set_keys[b];
            b++;
         end
         o++;
      end
      while (a < mid) begin
         merge_keys[o] = set_keys[a];
         a++;
         o++;
      end
      while (b < set_count) begin
         merge_keys[o] = set_keys[b];
         b++;
         o++;
      end
      for (int unsigned i = 0; i < set_count; i++)
         set_keys[i] = merge_keys[i];
   endfunction

   function automatic void predict_word(bit action, hism_pkg::key_type key, bit fin);
      sorted_word_type w;
      if (action == ACT_LOAD) begin
         if (set_sorted) begin
            set_sorted = 1'b0;
            set_count = 0;
            fetch_index = 0;
         end
         if (set_count < hism_pkg::MAX_KEYS) begin
            set_keys[set_count] = key;
            set_count++;
         end
         if (fin) begin
            sort_halves_and_merge();
            fetch_index = 0;
            set_sorted = 1'b1;
         end
      end else begin
         if (!set_sorted || fetch_index >= set_count) begin
            w.key = '0;
            w.last = 1'b0;
            w.empty = 1'b1;
         end else begin
            w.key = set_keys[fetch_index];
            w.last = (fetch_index + 1 == set_count);
            w.empty = 1'b0;
            fetch_index++;
         end
         expected_sorted.push_back(w);
      end
   endfunction

   task automatic send_word(bit action, hism_pkg::key_type key, bit fin);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= action;
      req_key_value <= key;
      req_final_key <= fin;
      do @(posedge clock); while (req_stall);
      predict_word(action, key, fin);
      sent_words++;
   endtask

   function automatic hism_pkg::key_type rand_key();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return KEY_MAX;
               1: return KEY_MIN;
               2: return '0;
               default: return -1;
            endcase
         end
         1, 2, 3: return hism_pkg::key_type'($urandom_range(0, 15)) - 8;
         default: return hism_pkg::key_type'($urandom);
      endcase
   endfunction

   task automatic fetch_words(int count);
      for (int i = 0; i < count; i++)
         send_word(ACT_FETCH, hism_pkg::key_type'($urandom), 1'($urandom_range(0, 1)));
   endtask

   task automatic test_reset_fetch();
      send_word(ACT_FETCH, KEY_MAX, 1'b0);
      send_word(ACT_FETCH, KEY_MIN, 1'b1);
   endtask

   task automatic test_extreme_keys();
      send_word(ACT_LOAD, KEY_MAX, 1'b0);
      send_word(ACT_LOAD, KEY_MIN, 1'b0);
      send_word(ACT_LOAD, '0, 1'b0);
      send_word(ACT_LOAD, -1, 1'b0);
      send_word(ACT_LOAD, KEY_MAX, 1'b0);
      send_word(ACT_LOAD, KEY_MIN, 1'b1);
      fetch_words(7);
   endtask

   task automatic test_small_sets();
      // single key, then a pair interrupted by a new set mid-fetch
      send_word(ACT_LOAD, 32'sd5, 1'b1);
      fetch_words(2);
      send_word(ACT_LOAD, 32'sd9, 1'b0);
      send_word(ACT_LOAD, -32'sd9, 1'b1);
      fetch_words(1);
      send_word(ACT_LOAD, 32'sd3, 1'b0);
      fetch_words(1);
      send_word(ACT_LOAD, 32'sd3, 1'b1);
      fetch_words(2);
   endtask

   task automatic test_full_store_backpressure();
      for (int i = 0; i < hism_pkg::MAX_KEYS + 2; i++)
         send_word(ACT_LOAD, rand_key(), i == hism_pkg::MAX_KEYS + 1);
      hold_request = 300;
      fetch_words(hism_pkg::MAX_KEYS + 2);
   endtask

   task automatic run_random_set();
      int n;
      int stray_at;
      int fetches;
      case ($urandom_range(0, 19))
         0:             n = $urandom_range(65, 300);
         1, 2, 3, 4, 5: n = $urandom_range(13, 64);
         default:       n = $urandom_range(1, 12);
      endcase
      stray_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
      for (int i = 0; i < n; i++) begin
         if (i == stray_at)
            send_word(ACT_FETCH, hism_pkg::key_type'($urandom), 1'($urandom_range(0, 1)));
         send_word(ACT_LOAD, rand_key(), i == n - 1);
      end
      fetches = (n > hism_pkg::MAX_KEYS) ? hism_pkg::MAX_KEYS : n;
      case ($urandom_range(0, 9))
         0:       fetches = $urandom_range(0, fetches);
         1, 2:    fetches = fetches + $urandom_range(1, 3);
         default: ;
      endcase
      fetch_words(fetches);
   endtask

   task automatic test_random_sets(int until_words);
      while (sent_words < until_words)
         run_random_set();
   endtask

   task automatic test_quiet_tail(int until_words);
      idle_on = 1'b0;
      test_random_sets(until_words);
   endtask

   // receiver: random stall bursts plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (stall_burst > 0) begin
         rsp_stall <= 1'b1;
         stall_burst = stall_burst - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_burst = $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      sorted_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sorted.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected word: key %0d last %0b empty %0b",
                        $signed(rsp_sorted_key), rsp_last_of_set, rsp_empty_read);
         end else begin
            w = expected_sorted.pop_front();
            if (rsp_sorted_key !== w.key || rsp_last_of_set !== w.last ||
                rsp_empty_read !== w.empty) begin
               failures++;
               if (failures <= 10)
                  $display({"mismatch: expected key %0d last %0b empty %0b, ",
                            "got key %0d last %0b empty %0b"},
                           w.key, w.last, w.empty, $signed(rsp_sorted_key),
                           rsp_last_of_set, rsp_empty_read);
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_fetch();
      test_extreme_keys();
      test_small_sets();
      test_full_store_backpressure();
      test_random_sets(1300);
      test_quiet_tail(1560);
      req_valid <= 1'b0;
      while (expected_sorted.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0 && expected_sorted.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
